// ----- rtl/core/xxbf_pkg.sv -----
`default_nettype none
package xxbf_pkg;

    localparam logic [63:0] PRIME1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] PRIME3 = 64'h165667B19E3779F9;
    localparam logic [63:0] PRIME4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] PRIME5 = 64'h27D4EB2F165667C5;

    localparam int DEF_FILTER_DEPTH = 65536;
    localparam int DEF_MAX_HASHES   = 16;

    localparam int NUM_HASHES_W  = 5;
    localparam int FILTER_BITS_W = 17;
    localparam int CFG_DATA_W    = 17;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_NUM_HASHES  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_BITS = 1'd1;

    localparam logic [NUM_HASHES_W-1:0]  NUM_HASHES_RST  = 5'd6;
    localparam logic [FILTER_BITS_W-1:0] FILTER_BITS_RST = 17'd65536;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] p;
    } mul_rsp_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/xxbf_mul.sv -----
`default_nettype none
module xxbf_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  xxbf_pkg::mul_req_t req,
    output xxbf_pkg::mul_rsp_t rsp
);
    import xxbf_pkg::*;

    // low 64 bits of a*b from three 32x32 partial products
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] lo_reg;
    logic [31:0] cr_reg;
    logic [63:0] p_reg;
    logic [31:0] x;
    logic [31:0] y;
    logic [63:0] prod;

    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                x = a_reg[31:0];
                y = b_reg[31:0];
            end
            2'd1:
            begin
                x = a_reg[31:0];
                y = b_reg[63:32];
            end
            default:
            begin
                x = a_reg[63:32];
                y = b_reg[31:0];
            end
        endcase
        prod = x * y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                2'd0:    lo_reg <= prod;
                2'd1:    cr_reg <= prod[31:0];
                2'd2:    cr_reg <= cr_reg + prod[31:0];
                default: p_reg  <= lo_reg + {cr_reg, 32'd0};
            endcase
        end
    end

    assign rsp = '{done: done_reg, p: p_reg};

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("multiply started while busy");

endmodule
`default_nettype wire

// ----- rtl/core/xxhash_bloom_filter.sv -----
`default_nettype none
// channel   direction  fields (low bit first)
// s_axis    in         tdata: data_byte[7:0], occurrence[39:8]; tuser: kind; tlast: last_byte
// m_axis    out        tdata: present[0]; one word per line
// cfg       in         index 0 num_hashes, 1 filter_bits
//
// A byte that closes neither a 32-byte stripe nor a line is taken in the idle state, which stays ready.
// Every 64-bit multiply runs on one shared 32x32 unit; a stripe close adds 8 multiplies.
// Line end: digest (up to 31 multiplies) then per hash ~5 multiplies plus a
// bit-serial remainder over the 64 hash bits and a filter RAM access.
// After reset the filter RAM is cleared one entry a cycle, all FILTER_DEPTH entries in turn.
// The result waits in an output register; a new line is taken meanwhile.
module xxhash_bloom_filter #(
    parameter int FILTER_DEPTH = xxbf_pkg::DEF_FILTER_DEPTH,
    parameter int MAX_HASHES   = xxbf_pkg::DEF_MAX_HASHES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [xxbf_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // data_byte, occurrence
    input  logic [0:0]                       s_axis_tuser,  // kind
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [xxbf_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // present
    input  logic                             cfg_we,
    input  logic [xxbf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [xxbf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import xxbf_pkg::*;

    localparam int IDX_W = $clog2(FILTER_DEPTH);
    localparam int MOD_W = IDX_W + 1;
    localparam int CNT_W = $clog2(MAX_HASHES + 1);

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_WAIT   = 5'd2;
    localparam logic [4:0] S_ST_A   = 5'd3;
    localparam logic [4:0] S_ST_B   = 5'd4;
    localparam logic [4:0] S_ST_C   = 5'd5;
    localparam logic [4:0] S_DG_0   = 5'd6;
    localparam logic [4:0] S_MG_A   = 5'd7;
    localparam logic [4:0] S_MG_B   = 5'd8;
    localparam logic [4:0] S_MG_C   = 5'd9;
    localparam logic [4:0] S_MG_D   = 5'd10;
    localparam logic [4:0] S_DG_LEN = 5'd11;
    localparam logic [4:0] S_TL_0   = 5'd12;
    localparam logic [4:0] S_TL_8B  = 5'd13;
    localparam logic [4:0] S_TL_8C  = 5'd14;
    localparam logic [4:0] S_TL_8D  = 5'd15;
    localparam logic [4:0] S_TL_4B  = 5'd16;
    localparam logic [4:0] S_TL_4C  = 5'd17;
    localparam logic [4:0] S_TL_1B  = 5'd18;
    localparam logic [4:0] S_TL_1C  = 5'd19;
    localparam logic [4:0] S_AV_0   = 5'd20;
    localparam logic [4:0] S_AV_1   = 5'd21;
    localparam logic [4:0] S_AV_2   = 5'd22;
    localparam logic [4:0] S_HS_0   = 5'd23;
    localparam logic [4:0] S_MOD    = 5'd24;
    localparam logic [4:0] S_FM_0   = 5'd25;
    localparam logic [4:0] S_FM_RD  = 5'd26;
    localparam logic [4:0] S_FM_NX  = 5'd27;
    localparam logic [4:0] S_OUT    = 5'd28;

    logic [4:0]               state_reg, state_next;
    logic [4:0]               ret_reg, ret_next;
    logic [IDX_W-1:0]         clr_reg, clr_next;
    logic                     line_open_reg, line_open_next;
    logic                     out_valid_reg, out_valid_next;
    logic [NUM_HASHES_W-1:0]  nh_reg, nh_next;
    logic [FILTER_BITS_W-1:0] fb_reg, fb_next;

    logic                     seen_reg, seen_next;
    logic                     last_reg, last_next;
    logic                     kind_reg, kind_next;
    logic [31:0]              len_reg, len_next;
    logic [31:0]              seed_reg, seed_next;
    logic [63:0]              lane_reg [4];
    logic [63:0]              lane_next [4];
    logic [63:0]              stripe_reg [4];
    logic [63:0]              h_reg, h_next;
    logic [63:0]              dig_reg, dig_next;
    logic                     tail_dig_reg, tail_dig_next;
    logic [4:0]               pos_reg, pos_next;
    logic [4:0]               rem_reg, rem_next;
    logic [1:0]               i_reg, i_next;
    logic [CNT_W-1:0]         k_reg, k_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [MOD_W-1:0]         mod_reg, mod_next;
    logic [MOD_W-1:0]         rm_reg, rm_next;
    logic [63:0]              s_reg, s_next;
    logic [5:0]               bit_reg, bit_next;
    logic                     all_reg, all_next;
    logic                     present_reg, present_next;

    logic                     filter_mem [FILTER_DEPTH];
    logic                     rd_reg;
    logic                     mem_we;
    logic                     mem_wd;
    logic [IDX_W-1:0]         mem_addr;

    mul_req_t                 mul_req;
    mul_rsp_t                 mul_rsp;

    logic                     acc_in;
    logic [7:0]               in_byte;
    logic [31:0]              in_occ;
    logic [31:0]              cur_len;
    logic [31:0]              len_inc;
    logic [1:0]               wsel;
    logic [63:0]              src_word;
    logic [31:0]              src32;
    logic [7:0]               src_byte;
    logic [63:0]              lane_cur;
    logic [63:0]              p;
    logic [63:0]              av_out;
    logic [MOD_W:0]           trial;

    xxbf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign acc_in        = s_axis_tvalid && s_axis_tready;
    assign in_byte       = s_axis_tdata[7:0];
    assign in_occ        = s_axis_tdata[39:8];
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, present_reg};

    assign cur_len  = line_open_reg ? len_reg : 32'd0;
    assign len_inc  = cur_len + 32'd1;
    assign wsel     = (state_reg == S_ST_A) ? i_reg : pos_reg[4:3];
    assign src_word = tail_dig_reg ? dig_reg : stripe_reg[wsel];
    assign src32    = pos_reg[2] ? src_word[63:32] : src_word[31:0];
    assign src_byte = src_word[8*pos_reg[2:0] +: 8];
    assign lane_cur = lane_reg[i_reg];
    assign p        = mul_rsp.p;
    assign av_out   = p ^ (p >> 32);
    assign trial    = {rm_reg, s_reg[63]};
    assign mem_addr = (state_reg == S_CLEAR) ? clr_reg : rm_reg[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        clr_next       = clr_reg;
        line_open_next = line_open_reg;
        out_valid_next = out_valid_reg;
        nh_next        = nh_reg;
        fb_next        = fb_reg;
        seen_next      = seen_reg;
        last_next      = last_reg;
        kind_next      = kind_reg;
        len_next       = len_reg;
        seed_next      = seed_reg;
        lane_next      = lane_reg;
        h_next         = h_reg;
        dig_next       = dig_reg;
        tail_dig_next  = tail_dig_reg;
        pos_next       = pos_reg;
        rem_next       = rem_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        mod_next       = mod_reg;
        rm_next        = rm_reg;
        s_next         = s_reg;
        bit_next       = bit_reg;
        all_next       = all_reg;
        present_next   = present_reg;
        mem_we         = 1'b0;
        mem_wd         = 1'b0;
        mul_req        = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM_HASHES:  nh_next = cfg_data[NUM_HASHES_W-1:0];
                REG_FILTER_BITS: fb_next = cfg_data[FILTER_BITS_W-1:0];
                default:         ;
            endcase
        end

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_reg == IDX_W'(FILTER_DEPTH - 1))
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (acc_in)
                begin
                    if (!line_open_reg)
                    begin
                        seed_next    = in_occ;
                        lane_next[0] = {32'd0, in_occ} + PRIME1 + PRIME2;
                        lane_next[1] = {32'd0, in_occ} + PRIME2;
                        lane_next[2] = {32'd0, in_occ};
                        lane_next[3] = {32'd0, in_occ} - PRIME1;
                        seen_next    = 1'b0;
                    end
                    tail_dig_next  = 1'b0;
                    len_next       = len_inc;
                    line_open_next = !s_axis_tlast;
                    last_next      = s_axis_tlast;
                    kind_next      = s_axis_tuser[0];
                    if (len_inc[4:0] == 5'd0)
                    begin
                        i_next     = 2'd0;
                        state_next = S_ST_A;
                    end
                    else if (s_axis_tlast)
                        state_next = S_DG_0;
                end
            end
            S_WAIT:
            begin
                if (mul_rsp.done)
                    state_next = ret_reg;
            end
            S_ST_A:
            begin
                mul_req    = '{start: 1'b1, a: src_word, b: PRIME2};
                ret_next   = S_ST_B;
                state_next = S_WAIT;
            end
            S_ST_B:
            begin
                mul_req    = '{start: 1'b1, a: rotl64(lane_cur + p, 31), b: PRIME1};
                ret_next   = S_ST_C;
                state_next = S_WAIT;
            end
            S_ST_C:
            begin
                lane_next[i_reg] = p;
                if (i_reg == 2'd3)
                begin
                    seen_next  = 1'b1;
                    state_next = last_reg ? S_DG_0 : S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + 2'd1;
                    state_next = S_ST_A;
                end
            end
            S_DG_0:
            begin
                if (nh_reg == '0)
                    count_next = CNT_W'(1);
                else if (32'(nh_reg) > MAX_HASHES)
                    count_next = CNT_W'(MAX_HASHES);
                else
                    count_next = CNT_W'(nh_reg);
                if (fb_reg == '0)
                    mod_next = MOD_W'(1);
                else if (32'(fb_reg) > FILTER_DEPTH)
                    mod_next = MOD_W'(FILTER_DEPTH);
                else
                    mod_next = fb_reg[MOD_W-1:0];
                tail_dig_next = 1'b0;
                if (seen_reg)
                begin
                    h_next = rotl64(lane_reg[0], 1) + rotl64(lane_reg[1], 7) +
                             rotl64(lane_reg[2], 12) + rotl64(lane_reg[3], 18);
                    i_next     = 2'd0;
                    state_next = S_MG_A;
                end
                else
                begin
                    h_next     = {32'd0, seed_reg} + PRIME5;
                    state_next = S_DG_LEN;
                end
            end
            S_MG_A:
            begin
                mul_req    = '{start: 1'b1, a: lane_cur, b: PRIME2};
                ret_next   = S_MG_B;
                state_next = S_WAIT;
            end
            S_MG_B:
            begin
                mul_req    = '{start: 1'b1, a: rotl64(p, 31), b: PRIME1};
                ret_next   = S_MG_C;
                state_next = S_WAIT;
            end
            S_MG_C:
            begin
                mul_req    = '{start: 1'b1, a: h_reg ^ p, b: PRIME1};
                ret_next   = S_MG_D;
                state_next = S_WAIT;
            end
            S_MG_D:
            begin
                h_next = p + PRIME4;
                if (i_reg == 2'd3)
                    state_next = S_DG_LEN;
                else
                begin
                    i_next     = i_reg + 2'd1;
                    state_next = S_MG_A;
                end
            end
            S_DG_LEN:
            begin
                h_next     = h_reg + {32'd0, len_reg};
                rem_next   = len_reg[4:0];
                pos_next   = 5'd0;
                state_next = S_TL_0;
            end
            S_TL_0:
            begin
                if (rem_reg >= 5'd8)
                begin
                    mul_req    = '{start: 1'b1, a: src_word, b: PRIME2};
                    ret_next   = S_TL_8B;
                    state_next = S_WAIT;
                end
                else if (rem_reg >= 5'd4)
                begin
                    mul_req    = '{start: 1'b1, a: {32'd0, src32}, b: PRIME1};
                    ret_next   = S_TL_4B;
                    state_next = S_WAIT;
                end
                else if (rem_reg != 5'd0)
                begin
                    mul_req    = '{start: 1'b1, a: {56'd0, src_byte}, b: PRIME5};
                    ret_next   = S_TL_1B;
                    state_next = S_WAIT;
                end
                else
                    state_next = S_AV_0;
            end
            S_TL_8B:
            begin
                mul_req    = '{start: 1'b1, a: rotl64(p, 31), b: PRIME1};
                ret_next   = S_TL_8C;
                state_next = S_WAIT;
            end
            S_TL_8C:
            begin
                mul_req    = '{start: 1'b1, a: rotl64(h_reg ^ p, 27), b: PRIME1};
                ret_next   = S_TL_8D;
                state_next = S_WAIT;
            end
            S_TL_8D:
            begin
                h_next     = p + PRIME4;
                pos_next   = pos_reg + 5'd8;
                rem_next   = rem_reg - 5'd8;
                state_next = S_TL_0;
            end
            S_TL_4B:
            begin
                mul_req    = '{start: 1'b1, a: rotl64(h_reg ^ p, 23), b: PRIME2};
                ret_next   = S_TL_4C;
                state_next = S_WAIT;
            end
            S_TL_4C:
            begin
                h_next     = p + PRIME3;
                pos_next   = pos_reg + 5'd4;
                rem_next   = rem_reg - 5'd4;
                state_next = S_TL_0;
            end
            S_TL_1B:
            begin
                mul_req    = '{start: 1'b1, a: rotl64(h_reg ^ p, 11), b: PRIME1};
                ret_next   = S_TL_1C;
                state_next = S_WAIT;
            end
            S_TL_1C:
            begin
                h_next     = p;
                pos_next   = pos_reg + 5'd1;
                rem_next   = rem_reg - 5'd1;
                state_next = S_TL_0;
            end
            S_AV_0:
            begin
                mul_req    = '{start: 1'b1, a: h_reg ^ (h_reg >> 33), b: PRIME2};
                ret_next   = S_AV_1;
                state_next = S_WAIT;
            end
            S_AV_1:
            begin
                mul_req    = '{start: 1'b1, a: p ^ (p >> 29), b: PRIME3};
                ret_next   = S_AV_2;
                state_next = S_WAIT;
            end
            S_AV_2:
            begin
                if (!tail_dig_reg)
                begin
                    dig_next   = av_out;
                    k_next     = '0;
                    all_next   = 1'b1;
                    state_next = S_HS_0;
                end
                else
                begin
                    s_next     = av_out;
                    rm_next    = '0;
                    bit_next   = 6'd0;
                    state_next = S_MOD;
                end
            end
            S_HS_0:
            begin
                h_next        = 64'(k_reg) + PRIME5 + 64'd8;
                rem_next      = 5'd8;
                pos_next      = 5'd0;
                tail_dig_next = 1'b1;
                state_next    = S_TL_0;
            end
            S_MOD:
            begin
                if (trial >= {1'b0, mod_reg})
                    rm_next = MOD_W'(trial - {1'b0, mod_reg});
                else
                    rm_next = trial[MOD_W-1:0];
                s_next   = {s_reg[62:0], 1'b0};
                bit_next = bit_reg + 6'd1;
                if (bit_reg == 6'd63)
                    state_next = S_FM_0;
            end
            S_FM_0:
            begin
                if (!kind_reg)
                begin
                    mem_we     = 1'b1;
                    mem_wd     = 1'b1;
                    state_next = S_FM_NX;
                end
                else
                    state_next = S_FM_RD;
            end
            S_FM_RD:
            begin
                if (!rd_reg)
                    all_next = 1'b0;
                state_next = S_FM_NX;
            end
            S_FM_NX:
            begin
                k_next = k_reg + 1'b1;
                if (CNT_W'(k_reg + 1'b1) == count_reg)
                    state_next = S_OUT;
                else
                    state_next = S_HS_0;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    present_next   = kind_reg ? all_reg : 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ret_reg       <= S_IDLE;
            clr_reg       <= '0;
            line_open_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            nh_reg        <= NUM_HASHES_RST;
            fb_reg        <= FILTER_BITS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            clr_reg       <= clr_next;
            line_open_reg <= line_open_next;
            out_valid_reg <= out_valid_next;
            nh_reg        <= nh_next;
            fb_reg        <= fb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seen_reg     <= seen_next;
        last_reg     <= last_next;
        kind_reg     <= kind_next;
        len_reg      <= len_next;
        seed_reg     <= seed_next;
        lane_reg     <= lane_next;
        h_reg        <= h_next;
        dig_reg      <= dig_next;
        tail_dig_reg <= tail_dig_next;
        pos_reg      <= pos_next;
        rem_reg      <= rem_next;
        i_reg        <= i_next;
        k_reg        <= k_next;
        count_reg    <= count_next;
        mod_reg      <= mod_next;
        rm_reg       <= rm_next;
        s_reg        <= s_next;
        bit_reg      <= bit_next;
        all_reg      <= all_next;
        present_reg  <= present_next;
        if (acc_in)
            stripe_reg[cur_len[4:3]][8*cur_len[2:0] +: 8] <= in_byte;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            filter_mem[mem_addr] <= mem_wd;
        rd_reg <= filter_mem[mem_addr];
    end

    a_rem_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FM_0) |-> (rm_reg < mod_reg))
        else $error("filter index not below modulus");

    a_hash_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HS_0) |-> (k_reg < count_reg))
        else $error("hash counter past count");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> (out_valid_reg && $stable(present_reg)))
        else $error("output word changed while stalled");

endmodule
`default_nettype wire
